>>> rtl/core/el2csr_pkg.sv
`default_nettype none
package el2csr_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SELF      = 3'd1;
  localparam logic [2:0] ST_SRC_ORDER = 3'd2;
  localparam logic [2:0] ST_DST_ORDER = 3'd3;
  localparam logic [2:0] ST_DUP       = 3'd4;

  localparam logic [1:0] KIND_DROP = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;
  } cls_t;

endpackage
`default_nettype wire

>>> rtl/core/el2csr_front.sv
`default_nettype none
module el2csr_front #(
  parameter int NODE_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [NODE_BITS-1:0]  in_src_node,
  input  wire  [NODE_BITS-1:0]  in_dst_node,
  input  wire                   in_end_of_stream,
  input  wire                   q_full,
  output logic                  q_push,
  output el2csr_pkg::cls_t      q_cls,
  output logic [NODE_BITS:0]    q_fill_first,
  output logic [NODE_BITS-1:0]  q_fill_count,
  output logic [NODE_BITS-1:0]  q_iso_add,
  output logic [NODE_BITS-1:0]  q_dst
);

  logic [NODE_BITS-1:0] cur_r, cur_nxt;
  logic [NODE_BITS-1:0] last_r, last_nxt;
  logic [NODE_BITS:0]   cur_inc;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_dst    = in_dst_node;
  assign cur_inc  = {1'b0, cur_r} + (NODE_BITS+1)'(1);

  always_comb begin
    q_cls.kind   = el2csr_pkg::KIND_DROP;
    q_cls.status = el2csr_pkg::ST_OK;
    q_fill_first = '0;
    q_fill_count = '0;
    q_iso_add    = '0;
    cur_nxt      = cur_r;
    last_nxt     = last_r;
    if (in_end_of_stream) begin
      q_cls.kind   = el2csr_pkg::KIND_EOS;
      q_fill_first = cur_inc;
      q_fill_count = NODE_BITS'(1);
    end else if (in_src_node == in_dst_node) begin
      q_cls.status = el2csr_pkg::ST_SELF;
    end else if (in_src_node < cur_r) begin
      q_cls.status = el2csr_pkg::ST_SRC_ORDER;
    end else if (in_src_node == cur_r) begin
      if (last_r > in_dst_node) begin
        q_cls.status = el2csr_pkg::ST_DST_ORDER;
      end else if (last_r == in_dst_node) begin
        q_cls.status = el2csr_pkg::ST_DUP;
      end else begin
        q_cls.kind = el2csr_pkg::KIND_EDGE;
        last_nxt   = in_dst_node;
      end
    end else begin
      q_cls.kind   = el2csr_pkg::KIND_EDGE;
      q_fill_first = cur_inc;
      q_fill_count = in_src_node - cur_r;
      q_iso_add    = in_src_node + ~cur_r;
      cur_nxt      = in_src_node;
      last_nxt     = in_dst_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      last_r <= '0;
    end else if (q_push) begin
      cur_r  <= cur_nxt;
      last_r <= last_nxt;
    end
  end

  a_src_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cur_r >= $past(cur_r))
    else $error("current source moved backward");

  a_last_only_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(q_push && q_cls.kind == el2csr_pkg::KIND_EDGE)
      |-> $stable(last_r))
    else $error("last destination changed without an accepted edge");

endmodule
`default_nettype wire

>>> rtl/core/el2csr_queue.sv
`default_nettype none
module el2csr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire  [WIDTH-1:0] push_data,
  input  wire              pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/core/el2csr_back.sv
`default_nettype none
module el2csr_back #(
  parameter int NODE_BITS   = 32,
  parameter int OFFSET_BITS = 48
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire                     cfg_wr_data,
  input  wire                     q_not_empty,
  output logic                    q_pop,
  input  wire el2csr_pkg::cls_t   q_cls,
  input  wire  [NODE_BITS:0]      q_fill_first,
  input  wire  [NODE_BITS-1:0]    q_fill_count,
  input  wire  [NODE_BITS-1:0]    q_iso_add,
  input  wire  [NODE_BITS-1:0]    q_dst,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [2:0]              out_status,
  output logic                    out_edge_valid,
  output logic [NODE_BITS-1:0]    out_edge_word,
  output logic [NODE_BITS:0]      out_fill_first,
  output logic [NODE_BITS-1:0]    out_fill_count,
  output logic [OFFSET_BITS-1:0]  out_fill_value,
  output logic [OFFSET_BITS-1:0]  out_edges_so_far,
  output logic [NODE_BITS-1:0]    out_isolated_so_far
);

  logic                   narrow_r;
  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] bo_r, bo_nxt;
  logic [OFFSET_BITS-1:0] et_r, et_nxt;
  logic [NODE_BITS-1:0]   iso_r, iso_nxt;
  logic [OFFSET_BITS:0]   bo_sum, et_sum;
  logic [NODE_BITS:0]     iso_sum;
  logic [OFFSET_BITS-1:0] step;
  logic                   is_edge;

  logic [2:0]             status_r;
  logic                   edge_valid_r;
  logic [NODE_BITS-1:0]   edge_word_r;
  logic [NODE_BITS:0]     fill_first_r;
  logic [NODE_BITS-1:0]   fill_count_r;
  logic [OFFSET_BITS-1:0] fill_value_r;

  assign q_pop   = q_not_empty && (!out_valid_r || !out_stall);
  assign step    = narrow_r ? OFFSET_BITS'(4) : OFFSET_BITS'(8);
  assign bo_sum  = {1'b0, bo_r} + {1'b0, step};
  assign et_sum  = {1'b0, et_r} + (OFFSET_BITS+1)'(1);
  assign iso_sum = {1'b0, iso_r} + {1'b0, q_iso_add};

  always_comb begin
    bo_nxt  = bo_r;
    et_nxt  = et_r;
    iso_nxt = iso_r;
    is_edge = 1'b0;
    case (q_cls.kind)
      el2csr_pkg::KIND_EDGE: begin
        is_edge = 1'b1;
        bo_nxt  = bo_sum[OFFSET_BITS] ? '1 : bo_sum[OFFSET_BITS-1:0];
        et_nxt  = et_sum[OFFSET_BITS] ? '1 : et_sum[OFFSET_BITS-1:0];
        iso_nxt = iso_sum[NODE_BITS] ? '1 : iso_sum[NODE_BITS-1:0];
      end
      el2csr_pkg::KIND_EOS: begin
        is_edge = 1'b0;
      end
      default: begin
        is_edge = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r    <= 1'b1;
      out_valid_r <= 1'b0;
      bo_r        <= '0;
      et_r        <= '0;
      iso_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        narrow_r <= cfg_wr_data;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
        bo_r        <= bo_nxt;
        et_r        <= et_nxt;
        iso_r       <= iso_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r     <= q_cls.status;
      edge_valid_r <= is_edge;
      edge_word_r  <= is_edge ? q_dst : '0;
      fill_first_r <= q_fill_first;
      fill_count_r <= q_fill_count;
      fill_value_r <= (q_fill_count != '0) ? bo_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_edge_valid      = edge_valid_r;
  assign out_edge_word       = edge_word_r;
  assign out_fill_first      = fill_first_r;
  assign out_fill_count      = fill_count_r;
  assign out_fill_value      = fill_value_r;
  assign out_edges_so_far    = et_r;
  assign out_isolated_so_far = iso_r;

  a_offset_only_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(q_pop && q_cls.kind == el2csr_pkg::KIND_EDGE)
      |-> $stable(bo_r) && $stable(et_r))
    else $error("offset or edge total moved without an accepted edge");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> et_r >= $past(et_r) && iso_r >= $past(iso_r))
    else $error("saturating total decreased");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fill_count_r == '0 |-> fill_first_r == '0 && fill_value_r == '0)
    else $error("empty fill carries nonzero first entry or value");

endmodule
`default_nettype wire

>>> rtl/core/sorted_edge_list_to_csr.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   in_src_node, in_dst_node, in_end_of_stream
// out      output     out_valid/out_stall out_status .. out_isolated_so_far
// cfg      input      cfg_wr_en           cfg_wr_data (narrow_edges)
//
// One edge per cycle while out_stall is low; output is registered after the queue.
// The front stage classifies against its own source/destination registers at accept.
// A 2-entry queue separates classification from the offset and counter update stage.
// rst_n is synchronous; it sets narrow_edges to 1 and zeroes counters and pointers.
// in_stall rises only when the queue is full, i.e. after out_stall backs it up.
`default_nettype none
module sorted_edge_list_to_csr #(
  parameter int NODE_BITS   = 32,
  parameter int OFFSET_BITS = 48
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire                     cfg_wr_data,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [NODE_BITS-1:0]    in_src_node,
  input  wire  [NODE_BITS-1:0]    in_dst_node,
  input  wire                     in_end_of_stream,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [2:0]              out_status,
  output logic                    out_edge_valid,
  output logic [NODE_BITS-1:0]    out_edge_word,
  output logic [NODE_BITS:0]      out_fill_first,
  output logic [NODE_BITS-1:0]    out_fill_count,
  output logic [OFFSET_BITS-1:0]  out_fill_value,
  output logic [OFFSET_BITS-1:0]  out_edges_so_far,
  output logic [NODE_BITS-1:0]    out_isolated_so_far
);

  localparam int QW = $bits(el2csr_pkg::cls_t) + (NODE_BITS + 1) + 3 * NODE_BITS;

  el2csr_pkg::cls_t      f_cls, b_cls;
  logic                  f_push, q_full, q_not_empty, b_pop;
  logic [NODE_BITS:0]    f_fill_first, b_fill_first;
  logic [NODE_BITS-1:0]  f_fill_count, b_fill_count;
  logic [NODE_BITS-1:0]  f_iso_add, b_iso_add;
  logic [NODE_BITS-1:0]  f_dst, b_dst;
  logic [QW-1:0]         q_in, q_out;

  el2csr_front #(.NODE_BITS(NODE_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_src_node      (in_src_node),
    .in_dst_node      (in_dst_node),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (f_push),
    .q_cls            (f_cls),
    .q_fill_first     (f_fill_first),
    .q_fill_count     (f_fill_count),
    .q_iso_add        (f_iso_add),
    .q_dst            (f_dst)
  );

  assign q_in = {f_cls, f_fill_first, f_fill_count, f_iso_add, f_dst};
  assign {b_cls, b_fill_first, b_fill_count, b_iso_add, b_dst} = q_out;

  el2csr_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .pop       (b_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  el2csr_back #(.NODE_BITS(NODE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_not_empty         (q_not_empty),
    .q_pop               (b_pop),
    .q_cls               (b_cls),
    .q_fill_first        (b_fill_first),
    .q_fill_count        (b_fill_count),
    .q_iso_add           (b_iso_add),
    .q_dst               (b_dst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_edge_valid      (out_edge_valid),
    .out_edge_word       (out_edge_word),
    .out_fill_first      (out_fill_first),
    .out_fill_count      (out_fill_count),
    .out_fill_value      (out_fill_value),
    .out_edges_so_far    (out_edges_so_far),
    .out_isolated_so_far (out_isolated_so_far)
  );

endmodule
`default_nettype wire
